### sv/tccur_pkg.sv
`default_nettype none

package tccur_pkg;

  localparam int MaxColumns = 256;
  localparam int MaxRows    = 128;
  localparam int TabWidth   = 8;

  localparam int ColW  = $clog2(MaxColumns);
  localparam int RowW  = $clog2(MaxRows);
  localparam int ColsW = ColW + 1;
  localparam int RowsW = RowW + 1;
  localparam int TabW  = $clog2(TabWidth);

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_FG      = 2'd2;
  localparam logic [1:0] REG_BG      = 2'd3;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [2:0] K_CHAR      = 3'd0;
  localparam logic [2:0] K_NEWLINE   = 3'd1;
  localparam logic [2:0] K_RETURN    = 3'd2;
  localparam logic [2:0] K_TAB       = 3'd3;
  localparam logic [2:0] K_BACKSPACE = 3'd4;
  localparam logic [2:0] K_SET       = 3'd5;
  localparam logic [2:0] K_CLEAR     = 3'd6;
  localparam logic [2:0] K_NOP       = 3'd7;

  typedef logic [2:0] kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [15:0] target_column;
    logic [15:0] target_row;
  } in_item_t;

  typedef struct packed {
    logic            cell_write;
    logic [ColW-1:0] cell_column;
    logic [RowW-1:0] cell_row;
    logic [7:0]      cell_char;
    logic [3:0]      cell_foreground;
    logic [3:0]      cell_background;
    logic            scroll_request;
    logic            clear_request;
    logic [ColW-1:0] cursor_column;
    logic [RowW-1:0] cursor_row;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_code;
    logic [15:0] target_column;
    logic [15:0] target_row;
  } cmd_t;

  typedef struct packed {
    logic [ColsW-1:0] columns;
    logic [RowsW-1:0] rows;
    logic [3:0]       fg;
    logic [3:0]       bg;
  } cfg_t;

endpackage

`default_nettype wire

### sv/text_console_cursor_engine_core.sv
// text console cursor engine
// input queue: command carries op, char_code, target_column, target_row;
//   a transfer happens on a clock edge with push high and full low
// result queue: the oldest result sits on result while empty is low;
//   a transfer happens on a clock edge with pop high and empty low
// one result per command, in command order
// a command is registered in the command queue, its result in the result queue
// throughput: one command per cycle while the receiver keeps popping; the
//   cursor update is a combinational compare and increment in the back end, fed
//   by a two-entry command queue and draining into a two-entry result queue
// config: cfg_write with cfg_index selects columns, rows, foreground, background;
//   write only while the block holds no commands or results
// reset (rst, synchronous): both queues empty, cursor at column 0 row 0,
//   80 columns, 25 rows, foreground 15, background 0
// when the receiver stalls, results pile up in the result queue, then the
//   command queue fills and full rises; nothing is dropped
`default_nettype none

module text_console_cursor_engine_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire tccur_pkg::in_item_t  command,
  output logic                      full,
  output logic                      empty,
  input  wire logic                 pop,
  output tccur_pkg::out_item_t      result,
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [tccur_pkg::ColsW-1:0] cfg_data
);
  import tccur_pkg::*;

  cfg_t      cfg;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_take;
  logic      res_full;
  logic      res_push;
  out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns <= ColsW'(80);
      cfg.rows    <= RowsW'(25);
      cfg.fg      <= 4'd15;
      cfg.bg      <= 4'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLUMNS: cfg.columns <= cfg_data;
        REG_ROWS:    cfg.rows    <= cfg_data[RowsW-1:0];
        REG_FG:      cfg.fg      <= cfg_data[3:0];
        REG_BG:      cfg.bg      <= cfg_data[3:0];
        default:     cfg         <= cfg;
      endcase
    end
  end

  tccur_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .command   (command),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  tccur_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  tccur_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    !empty && result.clear_request |->
      result.cursor_column == '0 && result.cursor_row == '0 && !result.cell_write)
    else $error("clear without cursor home");

  a_no_issue_when_full: assert property (@(posedge clk) disable iff (rst)
    res_full |-> !cmd_take)
    else $error("command issued into full result queue");

  a_scroll_put_only: assert property (@(posedge clk) disable iff (rst)
    !empty && result.scroll_request |-> !result.clear_request)
    else $error("scroll and clear together");

endmodule

`default_nettype wire

### sv/tccur_front.sv
`default_nettype none

module tccur_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire tccur_pkg::in_item_t command,
  output logic                     full,
  output logic                     cmd_valid,
  output tccur_pkg::cmd_t          cmd,
  input  wire logic                cmd_take
);
  import tccur_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       classified;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    classified.char_code     = command.char_code;
    classified.target_column = command.target_column;
    classified.target_row    = command.target_row;
    unique case (command.op)
      OP_PUT: begin
        unique case (command.char_code)
          CH_NEWLINE:   classified.kind = K_NEWLINE;
          CH_RETURN:    classified.kind = K_RETURN;
          CH_TAB:       classified.kind = K_TAB;
          CH_BACKSPACE: classified.kind = K_BACKSPACE;
          default:      classified.kind = K_CHAR;
        endcase
      end
      OP_SET:   classified.kind = K_SET;
      OP_CLEAR: classified.kind = K_CLEAR;
      default:  classified.kind = K_NOP;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/tccur_back.sv
`default_nettype none

module tccur_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tccur_pkg::cfg_t  cfg,
  input  wire logic             cmd_valid,
  input  wire tccur_pkg::cmd_t  cmd,
  output logic                  cmd_take,
  input  wire logic             res_full,
  output logic                  res_push,
  output tccur_pkg::out_item_t  res
);
  import tccur_pkg::*;

  logic [ColW-1:0] column_position;
  logic [RowW-1:0] row_position;
  logic [ColW-1:0] column_position_next;
  logic [RowW-1:0] row_position_next;

  always_comb begin
    logic [ColsW-1:0] w;
    logic [RowsW-1:0] h;
    logic [ColW-1:0]  wm1;
    logic [RowW-1:0]  hm1;
    logic [ColW-1:0]  x;
    logic [RowW-1:0]  y;
    logic [ColsW-1:0] xn;
    logic [RowsW-1:0] yn;
    logic [ColsW-1:0] tab_base;
    logic             is_put;

    if (cfg.columns == '0) w = ColsW'(1);
    else if (cfg.columns > ColsW'(MaxColumns)) w = ColsW'(MaxColumns);
    else w = cfg.columns;
    if (cfg.rows == '0) h = RowsW'(1);
    else if (cfg.rows > RowsW'(MaxRows)) h = RowsW'(MaxRows);
    else h = cfg.rows;
    wm1 = ColW'(w - ColsW'(1));
    hm1 = RowW'(h - RowsW'(1));
    x = (column_position > wm1) ? wm1 : column_position;
    y = (row_position > hm1) ? hm1 : row_position;

    xn       = {1'b0, x};
    yn       = {1'b0, y};
    tab_base = {1'b0, x} & ~ColsW'(TabWidth - 1);
    is_put   = 1'b0;
    res = '0;
    res.cell_foreground = cfg.fg;
    res.cell_background = cfg.bg;

    unique case (cmd.kind)
      K_NEWLINE: begin
        is_put = 1'b1;
        xn = '0;
        yn = {1'b0, y} + RowsW'(1);
      end
      K_RETURN: begin
        is_put = 1'b1;
        xn = '0;
      end
      K_TAB: begin
        is_put = 1'b1;
        xn = tab_base + ColsW'(TabWidth);
      end
      K_BACKSPACE: begin
        is_put = 1'b1;
        if (x != '0) begin
          xn = {1'b0, x} - ColsW'(1);
          res.cell_write  = 1'b1;
          res.cell_column = x - ColW'(1);
          res.cell_row    = y;
          res.cell_char   = CH_SPACE;
        end
      end
      K_CHAR: begin
        is_put = 1'b1;
        xn = {1'b0, x} + ColsW'(1);
        res.cell_write  = 1'b1;
        res.cell_column = x;
        res.cell_row    = y;
        res.cell_char   = cmd.char_code;
      end
      K_SET: begin
        xn = (cmd.target_column < 16'(w)) ? ColsW'(cmd.target_column) : {1'b0, wm1};
        yn = (cmd.target_row < 16'(h)) ? RowsW'(cmd.target_row) : {1'b0, hm1};
      end
      K_CLEAR: begin
        res.clear_request = 1'b1;
        xn = '0;
        yn = '0;
      end
      default: begin
      end
    endcase

    if (is_put) begin
      if (xn >= w) begin
        xn = '0;
        yn = yn + RowsW'(1);
      end
      if (yn >= h) begin
        res.scroll_request = 1'b1;
        yn = {1'b0, hm1};
      end
    end

    column_position_next = xn[ColW-1:0];
    row_position_next    = yn[RowW-1:0];
    res.cursor_column    = column_position_next;
    res.cursor_row       = row_position_next;
  end

  assign cmd_take = cmd_valid && !res_full;
  assign res_push = cmd_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (cmd_take) begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
    end
  end

endmodule

`default_nettype wire

### sv/tccur_outq.sv
`default_nettype none

module tccur_outq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 res_push,
  input  wire tccur_pkg::out_item_t res,
  output logic                      res_full,
  output logic                      empty,
  input  wire logic                 pop,
  output tccur_pkg::out_item_t      result
);
  import tccur_pkg::*;

  out_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign result   = slots[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tccur_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int CycleLimit   = 200000;
  localparam int RandomPhases = 7;
  localparam int PhaseItems   = 62;
  localparam int HoldAfter    = 120;
  localparam int HoldCycles   = 80;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             push;
  in_item_t         command;
  logic             full;
  logic             empty;
  logic             pop;
  out_item_t        result;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  logic [ColsW-1:0] cfg_data;

  // cursor predictor state and its copy of the registers
  int        screen_cols;
  int        screen_rows;
  logic [3:0] fg_color;
  logic [3:0] bg_color;
  int        cur_col;
  int        cur_row;

  out_item_t pending_results[$];
  int        mismatches   = 0;
  int        results_seen = 0;
  int        cycle_count  = 0;

  text_console_cursor_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .command   (command),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_item_t advance_cursor(in_item_t c);
    int w;
    int h;
    int x;
    int y;
    out_item_t r;
    w = (screen_cols == 0) ? 1 : ((screen_cols > MaxColumns) ? MaxColumns : screen_cols);
    h = (screen_rows == 0) ? 1 : ((screen_rows > MaxRows) ? MaxRows : screen_rows);
    // a shrunk screen pulls the stored cursor inside first
    x = (cur_col > w - 1) ? w - 1 : cur_col;
    y = (cur_row > h - 1) ? h - 1 : cur_row;
    r = '0;
    r.cell_foreground = fg_color;
    r.cell_background = bg_color;
    case (c.op)
      OP_PUT: begin
        if (c.char_code == CH_NEWLINE) begin
          x = 0;
          y++;
        end else if (c.char_code == CH_RETURN) begin
          x = 0;
        end else if (c.char_code == CH_TAB) begin
          x = x + TabWidth - (x % TabWidth);
        end else if (c.char_code == CH_BACKSPACE) begin
          if (x > 0) begin
            x--;
            r.cell_write  = 1'b1;
            r.cell_column = x[ColW-1:0];
            r.cell_row    = y[RowW-1:0];
            r.cell_char   = CH_SPACE;
          end
        end else begin
          r.cell_write  = 1'b1;
          r.cell_column = x[ColW-1:0];
          r.cell_row    = y[RowW-1:0];
          r.cell_char   = c.char_code;
          x++;
        end
        if (x >= w) begin
          x = 0;
          y++;
        end
        if (y >= h) begin
          r.scroll_request = 1'b1;
          y = h - 1;
        end
      end
      OP_SET: begin
        x = (c.target_column < w) ? int'(c.target_column) : w - 1;
        y = (c.target_row < h) ? int'(c.target_row) : h - 1;
      end
      OP_CLEAR: begin
        r.clear_request = 1'b1;
        x = 0;
        y = 0;
      end
      default: ;
    endcase
    cur_col = x & 255;
    cur_row = y & 127;
    r.cursor_column = cur_col[ColW-1:0];
    r.cursor_row    = cur_row[RowW-1:0];
    return r;
  endfunction

  function automatic in_item_t cmd_of(logic [1:0] op, logic [7:0] ch,
                                      logic [15:0] tc, logic [15:0] tr);
    in_item_t c;
    c.op            = op;
    c.char_code     = ch;
    c.target_column = tc;
    c.target_row    = tr;
    return c;
  endfunction

  // expected transfer under the reset colors
  function automatic out_item_t shown(int wr, int col, int row, logic [7:0] ch,
                                      int scroll, int clr, int ccol, int crow);
    out_item_t r;
    r.cell_write      = wr[0];
    r.cell_column     = col[ColW-1:0];
    r.cell_row        = row[RowW-1:0];
    r.cell_char       = ch;
    r.cell_foreground = 4'hF;
    r.cell_background = 4'h0;
    r.scroll_request  = scroll[0];
    r.clear_request   = clr[0];
    r.cursor_column   = ccol[ColW-1:0];
    r.cursor_row      = crow[RowW-1:0];
    return r;
  endfunction

  function automatic in_item_t random_command();
    in_item_t c;
    int pick;
    c.char_code     = 8'($urandom_range(0, 255));
    c.target_column = 16'($urandom_range(0, 65535));
    c.target_row    = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      c.op = OP_PUT;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: c.char_code = CH_NEWLINE;
          1: c.char_code = CH_RETURN;
          2: c.char_code = CH_TAB;
          default: c.char_code = CH_BACKSPACE;
        endcase
      end
    end else if (pick < 85) begin
      c.op = OP_SET;
      if ($urandom_range(0, 1) == 1) begin
        c.target_column = 16'($urandom_range(0, screen_cols + 1));
        c.target_row    = 16'($urandom_range(0, screen_rows + 1));
      end
    end else if (pick < 93) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OpUnused;
    end
    return c;
  endfunction

  task automatic send_command(in_item_t c, bit typed, out_item_t typed_res);
    out_item_t predicted;
    command <= c;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = advance_cursor(c);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 3) != 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [ColsW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_COLUMNS: screen_cols = int'(val);
      REG_ROWS:    screen_rows = int'(val[7:0]);
      REG_FG:      fg_color = val[3:0];
      default:     bg_color = val[3:0];
    endcase
  endtask

  task automatic note_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin : stimulus
    dir_row_t dir_rows[$];
    int cols;
    int rows;
    int sent;
    bit paused;
    rst       <= 1'b1;
    push      <= 1'b0;
    command   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= '0;
    screen_cols = 80;
    screen_rows = 25;
    fg_color    = 4'hF;
    bg_color    = 4'h0;
    cur_col     = 0;
    cur_row     = 0;
    paused      = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset screen is 80 x 25
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, 8'h41, 16'h0, 16'h0), 1'b1,
                                  shown(1, 0, 0, 8'h41, 0, 0, 1, 0)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, CH_BACKSPACE, 16'h0, 16'h0), 1'b1,
                                  shown(1, 0, 0, CH_SPACE, 0, 0, 0, 0)});
    // backspace at the left edge does nothing
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, CH_BACKSPACE, 16'h0, 16'h0), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, CH_TAB, 16'h0, 16'h0), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 8, 0)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, CH_TAB, 16'h0, 16'h0), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 16, 0)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, CH_RETURN, 16'h0, 16'h0), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, CH_NEWLINE, 16'h0, 16'h0), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 0, 1)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_SET, 8'h00, 16'hFFFF, 16'hFFFF), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 79, 24)});
    // last cell: wrap and scroll
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, 8'hFF, 16'h0, 16'h0), 1'b1,
                                  shown(1, 79, 24, 8'hFF, 1, 0, 0, 24)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, CH_NEWLINE, 16'hFFFF, 16'hFFFF), 1'b1,
                                  shown(0, 0, 0, 8'h00, 1, 0, 0, 24)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_SET, 8'hFF, 16'h0, 16'h0), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 1, 0, 0)});
    dir_rows.push_back(dir_row_t'{cmd_of(OpUnused, 8'h41, 16'h1234, 16'h1234), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_SET, 8'h00, 16'd79, 16'd24), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 79, 24)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, CH_TAB, 16'h0, 16'h0), 1'b1,
                                  shown(0, 0, 0, 8'h00, 1, 0, 0, 24)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_SET, 8'h00, 16'd80, 16'd25), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 79, 24)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, CH_BACKSPACE, 16'h0, 16'h0), 1'b1,
                                  shown(1, 78, 24, CH_SPACE, 0, 0, 78, 24)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, 8'h00, 16'h0, 16'h0), 1'b1,
                                  shown(1, 78, 24, 8'h00, 0, 0, 79, 24)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_SET, 8'h00, 16'h8000, 16'h0001), 1'b1,
                                  shown(0, 0, 0, 8'h00, 0, 0, 79, 1)});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, 8'h80, 16'h0, 16'h0), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_PUT, 8'h7F, 16'hFFFF, 16'hFFFF), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{cmd_of(OpUnused, 8'hFF, 16'hFFFF, 16'hFFFF), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{cmd_of(OP_CLEAR, 8'h00, 16'h0, 16'h0), 1'b0, '0});

    foreach (dir_rows[i]) begin
      send_command(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
      idle_gap();
    end
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: begin cols = 1;   rows = 1;   end
        1: begin cols = 256; rows = 128; end
        2: begin cols = 8;   rows = 2;   end
        4: begin cols = 40;  rows = 12;  end
        5: begin cols = 3;   rows = 128; end
        default: begin
          cols = $urandom_range(1, 256);
          rows = $urandom_range(1, 128);
        end
      endcase
      write_reg(REG_COLUMNS, ColsW'(cols));
      write_reg(REG_ROWS, ColsW'(rows));
      write_reg(REG_FG, ColsW'((p == 0) ? 0 : ((p == 1) ? 15 : $urandom_range(0, 15))));
      write_reg(REG_BG, ColsW'((p == 0) ? 15 : ((p == 1) ? 0 : $urandom_range(0, 15))));
      cfg_write <= 1'b0;
      sent = 0;
      while (sent < PhaseItems) begin
        for (int k = $urandom_range(1, 16); k > 0 && sent < PhaseItems; k--) begin
          send_command(random_command(), 1'b0, '0);
          sent++;
        end
        // one pause mid-phase until the block has handed back everything
        if (p == 3 && !paused && sent >= PhaseItems / 2) begin
          paused = 1'b1;
          drain();
        end else begin
          idle_gap();
        end
      end
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[text_console_cursor_engine_core] OK");
    end else begin
      $display("[text_console_cursor_engine_core] ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int pop_pct;
    int span;
    bit held;
    pop <= 1'b0;
    pop_pct = 100;
    span    = 0;
    held    = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HoldAfter) begin
        // long stall so the block backs up and raises full
        held = 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        if (span == 0) begin
          span = 24;
          case ($urandom_range(0, 3))
            0, 1: pop_pct = 100;
            2:    pop_pct = 60;
            default: pop_pct = 25;
          endcase
        end
        span--;
        pop <= ($urandom_range(0, 99) < pop_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected transfer expected none actual %h", $time, result);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        note_field("cell_write", 16'(want.cell_write), 16'(result.cell_write));
        note_field("cell_column", 16'(want.cell_column), 16'(result.cell_column));
        note_field("cell_row", 16'(want.cell_row), 16'(result.cell_row));
        note_field("cell_char", 16'(want.cell_char), 16'(result.cell_char));
        note_field("cell_foreground", 16'(want.cell_foreground),
                   16'(result.cell_foreground));
        note_field("cell_background", 16'(want.cell_background),
                   16'(result.cell_background));
        note_field("scroll_request", 16'(want.scroll_request),
                   16'(result.scroll_request));
        note_field("clear_request", 16'(want.clear_request), 16'(result.clear_request));
        note_field("cursor_column", 16'(want.cursor_column), 16'(result.cursor_column));
        note_field("cursor_row", 16'(want.cursor_row), 16'(result.cursor_row));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[text_console_cursor_engine_core] ERROR");
      $finish;
    end
  end

endmodule

### sim.f
sv/tccur_pkg.sv
sv/tccur_front.sv
sv/tccur_back.sv
sv/tccur_outq.sv
sv/text_console_cursor_engine_core.sv
dv/tb_top.sv
